// ----- src/tlb_page_table_translator_macros.svh -----
// Assertion macros for the translator.
// Define ASSERT_OFF to compile the checks out.
`ifndef TLB_PAGE_TABLE_TRANSLATOR_MACROS_SVH
`define TLB_PAGE_TABLE_TRANSLATOR_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define PTT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed: same-cycle implication");

// next-cycle implication
`define PTT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed: next-cycle implication");

`else

`define PTT_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define PTT_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- src/ptt_pkg.sv -----
`timescale 1ns / 1ps

package ptt_pkg;

    localparam int TLB_ENTRIES = 16;
    localparam int PAGE_COUNT  = 256;
    localparam int FRAME_COUNT = 256;
    localparam int OFFSET_BITS = 8;

    localparam int ADDR_W  = 16;
    localparam int PAGE_W  = 8;
    localparam int FRAME_W = 8;
    localparam int COUNT_W = 16;

    localparam int TLB_IDX_W  = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
    localparam int TLB_FILL_W = $clog2(TLB_ENTRIES + 1);
    localparam int PT_IDX_W   = $clog2(PAGE_COUNT);
    localparam int PT_CMP_W   = PAGE_W + 1;
    localparam int NF_W       = $clog2(FRAME_COUNT + 1);

    typedef logic [ADDR_W-1:0]  t_addr;
    typedef logic [PAGE_W-1:0]  t_page;
    typedef logic [FRAME_W-1:0] t_frame;

    // TLB lookup answer
    typedef struct packed {
        logic   hit;
        t_frame frame;
    } t_tlb_look;

    // TLB push request
    typedef struct packed {
        logic   en;
        t_page  page;
        t_frame frame;
    } t_tlb_push;

endpackage

// ----- src/ptt_ram.sv -----
`timescale 1ns / 1ps

module ptt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/ptt_tlb.sv -----
`timescale 1ns / 1ps

module ptt_tlb import ptt_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_page     i_page,
    input  t_tlb_push i_push,
    output t_tlb_look o_look
);

    // slot 0 oldest, slot r_fill-1 newest
    t_page  r_tag [TLB_ENTRIES];
    t_frame r_frm [TLB_ENTRIES];
    logic [TLB_FILL_W-1:0] r_fill;
    logic                  full;

    assign full = (r_fill >= TLB_FILL_W'(TLB_ENTRIES));

    // newest match wins: later slots override
    always_comb begin
        o_look = '0;
        for (int j = 0; j < TLB_ENTRIES; j++) begin
            if ((TLB_FILL_W'(j) < r_fill) && (r_tag[j] == i_page)) begin
                o_look.hit   = 1'b1;
                o_look.frame = r_frm[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_push.en && !full) begin
            r_fill <= r_fill + 1'b1;
        end
    end

    for (genvar j = 0; j < TLB_ENTRIES; j++) begin : g_slot
        if (j == TLB_ENTRIES - 1) begin : g_top
            always_ff @(posedge i_clk) begin
                if (i_push.en) begin
                    if (full || (r_fill[TLB_IDX_W-1:0] == TLB_IDX_W'(j))) begin
                        r_tag[j] <= i_push.page;
                        r_frm[j] <= i_push.frame;
                    end
                end
            end
        end else begin : g_mid
            always_ff @(posedge i_clk) begin
                if (i_push.en) begin
                    if (full) begin
                        r_tag[j] <= r_tag[j+1];
                        r_frm[j] <= r_frm[j+1];
                    end else if (r_fill[TLB_IDX_W-1:0] == TLB_IDX_W'(j)) begin
                        r_tag[j] <= i_push.page;
                        r_frm[j] <= i_push.frame;
                    end
                end
            end
        end
    end

endmodule

// ----- src/tlb_page_table_translator.sv -----
`timescale 1ns / 1ps
// Channel    Direction  Handshake             Word
// ---------  ---------  --------------------  ------------------------------------
// request    in         start && !busy        i_logical_address
// result     out        o_done (one cycle)    o_physical_address .. o_fault_total
//
// One word may be accepted every cycle; busy is held low.
// A result strobes o_done once its request has passed the registered page table
// read and then the TLB search and the result register.
// Reset (i_rst_n low, synchronous) empties the TLB, clears the page valid marks,
// the free frame pointer and both counters. No clearing pass follows.
// The receiver cannot stall; each result is there for one cycle only.

`include "tlb_page_table_translator_macros.svh"

module tlb_page_table_translator import ptt_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [ADDR_W-1:0]    i_logical_address,
    output logic                 o_done,
    output logic [ADDR_W-1:0]    o_physical_address,
    output logic [FRAME_W-1:0]   o_frame_number,
    output logic                 o_tlb_hit,
    output logic                 o_page_fault,
    output logic                 o_out_of_frames,
    output logic [COUNT_W-1:0]   o_hit_total,
    output logic [COUNT_W-1:0]   o_fault_total
);

    localparam t_addr OFS_MASK = ADDR_W'((1 << OFFSET_BITS) - 1);

    logic accept;
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // ---------------------------------------------------------------
    // Stage 0: capture the address, start the page table read
    // ---------------------------------------------------------------
    t_addr r_addr;
    logic  r_s1_valid;
    t_page in_page;
    t_frame pt_rdata;

    assign in_page = PAGE_W'(i_logical_address >> OFFSET_BITS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_addr <= i_logical_address;
        end
    end

    // ---------------------------------------------------------------
    // Stage 1: TLB search, page table decision, state update
    // ---------------------------------------------------------------
    t_page                 s1_page;
    logic                  beyond;
    logic [PAGE_COUNT-1:0] r_page_valid;
    logic [NF_W-1:0]       r_next_free;
    logic [COUNT_W-1:0]    r_hit_cnt;
    logic [COUNT_W-1:0]    r_fault_cnt;
    t_tlb_look             look;
    t_tlb_push             push;

    logic                  s1_hit;
    logic                  s1_fault;
    logic                  s1_none;
    t_frame                s1_frame;
    logic [COUNT_W-1:0]    n_hit_cnt;
    logic [COUNT_W-1:0]    n_fault_cnt;

    assign s1_page = PAGE_W'(r_addr >> OFFSET_BITS);
    assign beyond  = ({1'b0, s1_page} >= PT_CMP_W'(PAGE_COUNT));

    // The page table read for this word may race a fault write from the word
    // just ahead of it. That only matters for the same page, and such a word
    // always hits the TLB, since the one ahead was pushed; no bypass needed.
    ptt_ram #(
        .WIDTH (FRAME_W),
        .DEPTH (PAGE_COUNT)
    ) u_page_frames (
        .i_clk   (i_clk),
        .i_we    (s1_fault),
        .i_waddr (s1_page[PT_IDX_W-1:0]),
        .i_wdata (s1_frame),
        .i_raddr (in_page[PT_IDX_W-1:0]),
        .o_rdata (pt_rdata)
    );

    ptt_tlb u_tlb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_page  (s1_page),
        .i_push  (push),
        .o_look  (look)
    );

    always_comb begin
        s1_hit   = 1'b0;
        s1_fault = 1'b0;
        s1_none  = 1'b0;
        s1_frame = '0;
        if (r_s1_valid) begin
            if (look.hit) begin
                s1_hit   = 1'b1;
                s1_frame = look.frame;
            end else if (beyond) begin
                s1_none = 1'b1;
            end else if (r_page_valid[s1_page[PT_IDX_W-1:0]]) begin
                s1_frame = pt_rdata;
            end else if (r_next_free >= NF_W'(FRAME_COUNT)) begin
                s1_none = 1'b1;
            end else begin
                s1_fault = 1'b1;
                s1_frame = FRAME_W'(r_next_free);
            end
        end
    end

    // every mapped translation goes into the TLB, hits too
    assign push.en    = r_s1_valid && !s1_none;
    assign push.page  = s1_page;
    assign push.frame = s1_frame;

    // saturating counters
    assign n_hit_cnt   = (s1_hit && (r_hit_cnt != '1)) ? r_hit_cnt + 1'b1 : r_hit_cnt;
    assign n_fault_cnt = (s1_fault && (r_fault_cnt != '1)) ? r_fault_cnt + 1'b1 : r_fault_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_valid <= '0;
            r_next_free  <= '0;
            r_hit_cnt    <= '0;
            r_fault_cnt  <= '0;
        end else begin
            if (s1_fault) begin
                r_page_valid[s1_page[PT_IDX_W-1:0]] <= 1'b1;
                r_next_free <= r_next_free + 1'b1;
            end
            r_hit_cnt   <= n_hit_cnt;
            r_fault_cnt <= n_fault_cnt;
        end
    end

    // ---------------------------------------------------------------
    // Result register
    // ---------------------------------------------------------------
    logic               r_done;
    t_addr              r_phys;
    t_frame             r_frame;
    logic               r_hit;
    logic               r_fault;
    logic               r_none;
    logic [COUNT_W-1:0] r_hit_out;
    logic [COUNT_W-1:0] r_fault_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_phys      <= (ADDR_W'(s1_frame) << OFFSET_BITS) | (r_addr & OFS_MASK);
            r_frame     <= s1_frame;
            r_hit       <= s1_hit;
            r_fault     <= s1_fault;
            r_none      <= s1_none;
            r_hit_out   <= n_hit_cnt;
            r_fault_out <= n_fault_cnt;
        end
    end

    assign o_done             = r_done;
    assign o_physical_address = r_phys;
    assign o_frame_number     = r_frame;
    assign o_tlb_hit          = r_hit;
    assign o_page_fault       = r_fault;
    assign o_out_of_frames    = r_none;
    assign o_hit_total        = r_hit_out;
    assign o_fault_total      = r_fault_out;

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    `PTT_ASSERT_NEXT(a_word_flows, i_clk, i_rst_n, r_s1_valid, r_done)
    `PTT_ASSERT_NOW(a_flags_excl, i_clk, i_rst_n, r_done, $onehot0({r_hit, r_fault, r_none}))
    `PTT_ASSERT_NOW(a_fault_has_frame, i_clk, i_rst_n, s1_fault, r_next_free < NF_W'(FRAME_COUNT))
    `PTT_ASSERT_NOW(a_none_no_push, i_clk, i_rst_n, s1_none, !push.en && (s1_frame == '0))

endmodule
